// ===== src/rqfh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rqfh_pkg: shared types and constants of the ready queue picker.
// Holds the table geometry, the entry layout and the codes of the item fields.
// ----------------------------------------------------------------------------
package rqfh_pkg;

   // Table geometry.
   localparam int QueueDepth = 16;
   localparam int IdxW       = $clog2(QueueDepth);
   localparam int CntW       = $clog2(QueueDepth + 1);

   // Field widths.
   localparam int IdW   = 16;
   localparam int EstW  = 16;
   localparam int TimeW = 32;
   localparam int ProdW = TimeW + EstW;

   // Item mode codes.
   localparam logic MODE_ENQUEUE  = 1'b0;
   localparam logic MODE_DISPATCH = 1'b1;

   // Policy register codes.
   localparam logic POLICY_FIFO = 1'b0;
   localparam logic POLICY_HRRN = 1'b1;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_ENQUEUED   = 2'd0,
      ST_DISPATCHED = 2'd1,
      ST_EMPTY      = 2'd2,
      ST_FULL       = 2'd3
   } status_type;

   // One row of the ready table.
   typedef struct packed {
      logic [IdW-1:0]   id;
      logic [TimeW-1:0] arrival;
      logic [EstW-1:0]  estimate;
   } entry_type;

endpackage

`default_nettype wire

// ===== src/rqfh_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rqfh_if: handshake channels of the ready queue picker.
// Request, response and register write channels, each with valid and ready.
// ----------------------------------------------------------------------------
interface rqfh_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [15:0] proc_id;
   logic [15:0] burst_estimate;
   logic [31:0] now_time;

   modport source (output valid, mode, proc_id, burst_estimate, now_time, input ready);
   modport sink   (input valid, mode, proc_id, burst_estimate, now_time, output ready);
endinterface

interface rqfh_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [15:0] chosen_id;

   modport source (output valid, status, chosen_id, input ready);
   modport sink   (input valid, status, chosen_id, output ready);
endinterface

interface rqfh_csr_if;
   logic valid;
   logic ready;
   logic policy;

   modport source (output valid, policy, input ready);
   modport sink   (input valid, policy, output ready);
endinterface

`default_nettype wire

// ===== src/ready_queue_fifo_hrrn_picker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Enqueue, full and empty beats: the response is valid in the cycle after the request beat.
// Dispatch: the table is read one entry a cycle through a 4-deep compare pipeline, N
// entries in all (N = entries held under HRRN, 1 under FIFO); the response is loaded
// when the last is compared. The table is then compacted, one entry moved per cycle through
// the memory port; the next request is taken after the entries behind the chosen slot move.
// Reset empties the table and selects FIFO; table contents are not cleared.
// ----------------------------------------------------------------------------
// ready_queue_fifo_hrrn_picker: ready table with FIFO or HRRN dispatch.
// Keeps processes in arrival order in a memory and picks one per dispatch.
// ----------------------------------------------------------------------------
module ready_queue_fifo_hrrn_picker (
   input  wire           clock,
   input  wire           reset,
   rqfh_req_if.sink      req_bus,
   rqfh_rsp_if.source    rsp_bus,
   rqfh_csr_if.sink      csr_bus
);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_SCAN  = 3'b010,
      S_SHIFT = 3'b100
   } state_type;

   localparam int IdxW  = rqfh_pkg::IdxW;
   localparam int CntW  = rqfh_pkg::CntW;
   localparam int TimeW = rqfh_pkg::TimeW;
   localparam int EstW  = rqfh_pkg::EstW;
   localparam int IdW   = rqfh_pkg::IdW;
   localparam int ProdW = rqfh_pkg::ProdW;

   state_type state_ff, state_in;
   logic [CntW-1:0] count_ff, count_in;
   logic policy_ff;

   // Table memory.
   rqfh_pkg::entry_type mem_ff [rqfh_pkg::QueueDepth];
   rqfh_pkg::entry_type rd_data_ff;
   rqfh_pkg::entry_type wr_data;
   logic wr_en, rd_en;
   logic [IdxW-1:0] wr_addr, rd_addr;

   // Dispatch context.
   logic [TimeW-1:0] now_ff;
   logic [CntW-1:0]  scan_len_ff;
   logic [CntW-1:0]  issue_cnt_ff;

   // Scan pipeline: read, wait, products, compare.
   logic            s1_valid_ff, s1_last_ff;
   logic [IdxW-1:0] s1_idx_ff;
   logic            a_valid_ff, a_last_ff, a_first_ff;
   logic [IdxW-1:0] a_idx_ff;
   logic [TimeW-1:0] a_wait_ff;
   logic [EstW-1:0] a_est_ff;
   logic [IdW-1:0]  a_id_ff;
   logic            b_valid_ff, b_last_ff, b_first_ff;
   logic [IdxW-1:0] b_idx_ff;
   logic [TimeW-1:0] b_wait_ff;
   logic [EstW-1:0] b_est_ff;
   logic [IdW-1:0]  b_id_ff;
   logic [ProdW-1:0] p_wb_ff, p_bw_ff, p_wp_ff, p_pw_ff;
   logic            last_won_ff;

   // Best entry so far.
   logic [TimeW-1:0] best_wait_ff, best_wait_in;
   logic [EstW-1:0]  best_est_ff, best_est_in;
   logic [IdxW-1:0]  best_idx_ff, best_idx_in;
   logic [IdW-1:0]   best_id_ff, best_id_in;
   logic             won;
   logic             scan_done;

   // Compaction.
   logic [CntW-1:0] shift_addr_ff;
   logic            pend_ff;
   logic [IdxW-1:0] pend_addr_ff;
   logic            shift_done;

   // Response register.
   logic            rsp_valid_ff;
   logic [1:0]      rsp_status_ff;
   logic [IdW-1:0]  rsp_id_ff;
   logic            rsp_load;
   rqfh_pkg::status_type rsp_status_in;
   logic [IdW-1:0]  rsp_id_in;

   logic req_beat, is_full, is_empty;
   logic [TimeW-1:0] rd_wait;

   // Handshakes.
   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_bus.ready);
   assign req_beat      = req_bus.valid && req_bus.ready;
   assign is_full       = (count_ff == CntW'(rqfh_pkg::QueueDepth));
   assign is_empty      = (count_ff == '0);

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.status    = rsp_status_ff;
   assign rsp_bus.chosen_id = rsp_id_ff;

   // Policy register.
   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= rqfh_pkg::POLICY_FIFO;
      end else if (csr_bus.valid && csr_bus.ready) begin
         policy_ff <= csr_bus.policy;
      end
   end

   // Memory port selection: enqueue and compaction write, scan and compaction read.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = count_ff[IdxW-1:0];
      wr_data = rd_data_ff;
      rd_en   = 1'b0;
      rd_addr = issue_cnt_ff[IdxW-1:0];
      if (state_ff == S_IDLE) begin
         if (req_beat && req_bus.mode == rqfh_pkg::MODE_ENQUEUE && !is_full) begin
            wr_en            = 1'b1;
            wr_data.id       = req_bus.proc_id;
            wr_data.arrival  = req_bus.now_time;
            wr_data.estimate = (req_bus.burst_estimate == '0) ? EstW'(1)
                                                               : req_bus.burst_estimate;
         end
      end else if (state_ff == S_SCAN) begin
         rd_en = (issue_cnt_ff < scan_len_ff);
      end else begin
         rd_en   = (shift_addr_ff < count_ff);
         rd_addr = shift_addr_ff[IdxW-1:0];
         wr_en   = pend_ff;
         wr_addr = pend_addr_ff;
      end
   end

   // Table memory with registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   // Wait of the entry just read; arrival in the future counts as no wait.
   assign rd_wait = (now_ff >= rd_data_ff.arrival) ? (now_ff - rd_data_ff.arrival) : '0;

   // Compare: the first entry always wins; otherwise use products against the
   // previous entry when it just won, else against the held best.
   always_comb begin
      if (b_first_ff) begin
         won = 1'b1;
      end else if (last_won_ff) begin
         won = (p_wp_ff > p_pw_ff);
      end else begin
         won = (p_wb_ff > p_bw_ff);
      end
      best_wait_in = best_wait_ff;
      best_est_in  = best_est_ff;
      best_idx_in  = best_idx_ff;
      best_id_in   = best_id_ff;
      if (b_valid_ff && won) begin
         best_wait_in = b_wait_ff;
         best_est_in  = b_est_ff;
         best_idx_in  = b_idx_ff;
         best_id_in   = b_id_ff;
      end
   end

   assign scan_done  = (state_ff == S_SCAN) && b_valid_ff && b_last_ff;
   assign shift_done = (state_ff == S_SHIFT) && !rd_en && !pend_ff;

   // Scan pipeline registers.
   always_ff @(posedge clock) begin
      if (reset || state_ff != S_SCAN) begin
         s1_valid_ff <= 1'b0;
         a_valid_ff  <= 1'b0;
         b_valid_ff  <= 1'b0;
         last_won_ff <= 1'b0;
      end else begin
         s1_valid_ff <= rd_en;
         a_valid_ff  <= s1_valid_ff;
         b_valid_ff  <= a_valid_ff;
         last_won_ff <= b_valid_ff && won;
      end
   end

   always_ff @(posedge clock) begin
      s1_last_ff  <= (issue_cnt_ff + CntW'(1) == scan_len_ff);
      s1_idx_ff   <= issue_cnt_ff[IdxW-1:0];
      a_last_ff   <= s1_last_ff;
      a_first_ff  <= (s1_idx_ff == '0);
      a_idx_ff    <= s1_idx_ff;
      a_wait_ff   <= rd_wait;
      a_est_ff    <= rd_data_ff.estimate;
      a_id_ff     <= rd_data_ff.id;
      b_last_ff   <= a_last_ff;
      b_first_ff  <= a_first_ff;
      b_idx_ff    <= a_idx_ff;
      b_wait_ff   <= a_wait_ff;
      b_est_ff    <= a_est_ff;
      b_id_ff     <= a_id_ff;
      p_wb_ff     <= ProdW'(a_wait_ff) * ProdW'(best_est_ff);
      p_bw_ff     <= ProdW'(best_wait_ff) * ProdW'(a_est_ff);
      p_wp_ff     <= ProdW'(a_wait_ff) * ProdW'(b_est_ff);
      p_pw_ff     <= ProdW'(b_wait_ff) * ProdW'(a_est_ff);
      best_wait_ff <= best_wait_in;
      best_est_ff  <= best_est_in;
      best_idx_ff  <= best_idx_in;
      best_id_ff   <= best_id_in;
   end

   // The held-best products are taken from the best as it stands before this
   // cycle's compare; p_wb and p_bw above must use the registered best.
   // Dispatch context and compaction counters.
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE) begin
         now_ff       <= req_bus.now_time;
         scan_len_ff  <= (policy_ff == rqfh_pkg::POLICY_HRRN) ? count_ff : CntW'(1);
         issue_cnt_ff <= '0;
      end else if (rd_en && state_ff == S_SCAN) begin
         issue_cnt_ff <= issue_cnt_ff + CntW'(1);
      end
      if (scan_done) begin
         shift_addr_ff <= CntW'(best_idx_in) + CntW'(1);
      end else if (state_ff == S_SHIFT && rd_en) begin
         shift_addr_ff <= shift_addr_ff + CntW'(1);
      end
      pend_addr_ff <= shift_addr_ff[IdxW-1:0] - IdxW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset || state_ff != S_SHIFT) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= rd_en;
      end
   end

   // Control: state and entry count.
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               if (req_bus.mode == rqfh_pkg::MODE_ENQUEUE) begin
                  if (!is_full) begin
                     count_in = count_ff + CntW'(1);
                  end
               end else if (!is_empty) begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (scan_done) begin
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            if (shift_done) begin
               count_in = count_ff - CntW'(1);
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // Response beat source: immediate for enqueue and empty, end of scan for dispatch.
   always_comb begin
      rsp_load      = 1'b0;
      rsp_status_in = rqfh_pkg::ST_ENQUEUED;
      rsp_id_in     = '0;
      if (req_beat) begin
         if (req_bus.mode == rqfh_pkg::MODE_ENQUEUE) begin
            rsp_load      = 1'b1;
            rsp_status_in = is_full ? rqfh_pkg::ST_FULL : rqfh_pkg::ST_ENQUEUED;
         end else if (is_empty) begin
            rsp_load      = 1'b1;
            rsp_status_in = rqfh_pkg::ST_EMPTY;
         end
      end else if (scan_done) begin
         rsp_load      = 1'b1;
         rsp_status_in = rqfh_pkg::ST_DISPATCHED;
         rsp_id_in     = best_id_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_id_ff     <= rsp_id_in;
      end
   end

endmodule

`default_nettype wire
